/* design/pmv_pkg.sv */
// ----------------------------------------------------------------------------
// pmv_pkg
// Shared types, constants and shape tables of the plot marker vertex generator.
// ----------------------------------------------------------------------------
package pmv_pkg;

  // configuration register indexes
  localparam logic REG_STYLE = 1'b0;
  localparam logic REG_SIZE  = 1'b1;

  localparam logic [9:0]  STYLE_RESET = 10'd1;
  localparam logic [15:0] SIZE_RESET  = 16'd256;
  localparam logic [9:0]  VARIANT_FIRST = 10'd50;

  // rounded multiples of the reduced size, in issue order
  localparam int NUM_MAG = 7;
  localparam int MAG_W   = 20;
  localparam logic [2:0] MAG_LAST = 3'd6;

  // vertices per shape and packed pattern rows
  localparam int NV    = 24;
  localparam int CW    = 5;
  localparam int VW    = 2 * CW;
  localparam int PAT_W = NV * VW;

  typedef enum logic [2:0] {
    KIND_DOT   = 3'd0,
    KIND_SEG   = 3'd1,
    KIND_CIRC  = 3'd2,
    KIND_FCIRC = 3'd3,
    KIND_FAREA = 3'd4,
    KIND_PLINE = 3'd5,
    KIND_TRI   = 3'd6
  } kind_t;

  typedef enum logic [4:0] {
    PAT_NONE, PAT_PLUS, PAT_STAR, PAT_MULT, PAT_DSML, PAT_DMED, PAT_SQR,
    PAT_TUP, PAT_TDN, PAT_DIAM, PAT_CRST, PAT_CROSS, PAT_STRT, PAT_OSTAR,
    PAT_DCRS, PAT_SQDG, PAT_TRI3, PAT_OCTX, PAT_F3TR, PAT_O4TX, PAT_F4TX,
    PAT_DDTR, PAT_DDIA, PAT_O4TP, PAT_F4TP, PAT_CXTR, PAT_CRSX, PAT_FSQX,
    PAT_FSQP
  } pat_t;

  typedef struct packed {
    kind_t      kind;
    pat_t       pat;
    logic [4:0] len;
  } cls_t;

  // one classified request with its rounded multiples
  typedef struct packed {
    cls_t                          cls;
    logic [NUM_MAG-1:0][MAG_W-1:0] mag;
  } job_t;

  // coordinate codes: sign plus magnitude selector
  localparam logic [CW-1:0] Z  = 5'd0;
  localparam logic [CW-1:0] PU = 5'd1;
  localparam logic [CW-1:0] MU = 5'h1F;
  localparam logic [CW-1:0] P4 = 5'd2;
  localparam logic [CW-1:0] M4 = 5'h1E;
  localparam logic [CW-1:0] P2 = 5'd3;
  localparam logic [CW-1:0] M2 = 5'h1D;
  localparam logic [CW-1:0] PS = 5'd4;
  localparam logic [CW-1:0] MS = 5'h1C;
  localparam logic [CW-1:0] PD = 5'd5;
  localparam logic [CW-1:0] MD = 5'h1B;
  localparam logic [CW-1:0] PC = 5'd6;
  localparam logic [CW-1:0] MC = 5'h1A;
  localparam logic [CW-1:0] PE = 5'd7;
  localparam logic [CW-1:0] ME = 5'h19;
  localparam logic [CW-1:0] PO = 5'd8;
  localparam logic [CW-1:0] MO = 5'h18;

  // vertex 0 sits in the top bits
  localparam logic [PAT_W-1:0] PV_PLUS = {M4,Z, P4,Z, Z,M4, Z,P4, {(NV-4)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_STAR = {M4,Z, P4,Z, Z,M4, Z,P4, MS,MS, PS,PS, MS,PS, PS,MS,
    {(NV-8)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_MULT = {MS,MS, PS,PS, MS,PS, PS,MS, {(NV-4)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_DSML = {MU,Z, PU,Z, Z,MU, Z,PU, {(NV-4)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_DMED = {MU,MU, PU,MU, PU,PU, MU,PU, MU,MU,
    {(NV-5)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_SQR = {M4,M4, P4,M4, P4,P4, M4,P4, M4,M4,
    {(NV-5)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_TUP = {M4,P4, P4,P4, Z,M4, M4,P4, {(NV-4)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_TDN = {Z,P4, P4,M4, M4,M4, Z,P4, {(NV-4)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_DIAM = {MD,Z, Z,M4, PD,Z, Z,P4, MD,Z, {(NV-5)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_CRST = {
    M4,MC, M4,PC, MC,PC, M4,MC, MC,PC, MC,MC,
    MC,M4, MC,P4, PC,P4, MC,M4, PC,P4, PC,M4,
    PC,MC, PC,PC, P4,PC, PC,MC, P4,PC, P4,MC, {(NV-18)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_CROSS = {
    M4,MC, MC,MC, MC,M4, PC,M4, PC,MC, P4,MC,
    P4,PC, PC,PC, PC,P4, MC,P4, MC,PC, M4,PC, M4,MC, {(NV-13)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_STRT = {
    M4,PC, M2,ME, MC,PC, M2,ME, MD,M4, Z,M2,
    Z,M2, PD,M4, P2,ME, P2,ME, P4,PC, PC,PC,
    PC,PC, Z,P4, MC,PC, MC,PC, M2,ME, Z,M2,
    MC,PC, Z,M2, P2,ME, MC,PC, P2,ME, PC,PC};
  localparam logic [PAT_W-1:0] PV_OSTAR = {
    M4,PC, M2,ME, MD,M4, Z,M2, PD,M4, P2,ME,
    P4,PC, PC,PC, Z,P4, MC,PC, M4,PC, {(NV-11)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_DCRS = {M4,Z, Z,M4, P4,Z, Z,P4, M4,Z, P4,Z, Z,P4, Z,M4,
    {(NV-8)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_SQDG = {M4,M4, P4,M4, P4,P4, M4,P4, M4,M4, P4,P4, M4,P4,
    P4,M4, {(NV-8)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_TRI3 = {Z,Z, M2,P4, P2,P4, Z,Z, M2,M4, M4,Z, Z,Z, P4,Z,
    P2,M4, Z,Z, {(NV-10)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_OCTX = {
    M4,Z, M4,M2, M2,M4, P2,M4, P4,M2, P4,P2, P2,P4,
    M2,P4, M4,P2, M4,Z, P4,Z, Z,Z, Z,M4, Z,P4, Z,Z, {(NV-15)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_F3TR = {M4,Z, M2,P4, Z,Z, P2,P4, P4,Z, Z,Z, P2,M4,
    M2,M4, Z,Z, {(NV-9)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_O4TX = {
    Z,Z, P2,P4, P4,P2, Z,Z, P4,M2, P2,M4, Z,Z,
    M2,M4, M4,M2, Z,Z, M4,P2, M2,P4, Z,Z, {(NV-13)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_F4TX = {
    M4,P2, M2,P4, Z,Z, P2,P4, P4,P2, Z,Z,
    P4,M2, P2,M4, Z,Z, M2,M4, M4,M2, Z,Z, {(NV-12)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_DDTR = {
    Z,P4, MO,PO, Z,Z, MO,PO, M4,Z, Z,Z,
    M4,Z, MO,MO, Z,Z, MO,MO, Z,M4, Z,Z,
    Z,M4, PO,MO, Z,Z, PO,MO, P4,Z, Z,Z,
    P4,Z, PO,PO, Z,Z, PO,PO, Z,P4, Z,Z};
  localparam logic [PAT_W-1:0] PV_DDIA = {Z,P4, MO,PO, M4,Z, MO,MO, Z,M4, PO,MO, P4,Z,
    PO,PO, Z,P4, {(NV-9)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_O4TP = {
    Z,Z, P2,P4, M2,P4, P2,M4, M2,M4, Z,Z,
    P4,P2, P4,M2, M4,P2, M4,M2, Z,Z, {(NV-11)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_F4TP = {
    M2,P4, P2,P4, Z,Z, P4,P2, P4,M2, Z,Z,
    P2,M4, M2,M4, Z,Z, M4,M2, M4,P2, Z,Z, {(NV-12)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_CXTR = {
    M2,Z, M4,P2, M2,P4, M2,Z, M2,P4, Z,P2,
    M2,M4, M4,M2, P2,P4, M2,M4, P2,P4, P4,P2,
    P2,M4, Z,M2, P2,Z, P2,M4, P2,Z, P4,M2, {(NV-18)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_CRSX = {
    Z,P2, M2,P4, M4,P2, M2,Z, M4,M2, M2,M4, Z,M2,
    P2,M4, P4,M2, P2,Z, P4,P2, P2,P4, Z,P2, {(NV-13)*VW{1'b0}}};
  localparam logic [PAT_W-1:0] PV_FSQX = {
    M2,Z, M4,P2, M2,P4, M2,Z, M2,P4, Z,P2,
    P2,Z, Z,P2, P2,P4, P2,Z, P2,P4, P4,P2,
    M2,M4, M4,M2, M2,Z, M2,M4, M2,Z, Z,M2,
    P2,M4, Z,M2, P2,Z, P2,M4, P2,Z, P4,M2};
  localparam logic [PAT_W-1:0] PV_FSQP = {
    MC,PC, MC,P4, PC,P4, MC,PC, PC,P4, PC,PC,
    PC,MC, PC,PC, P4,PC, PC,MC, P4,PC, P4,MC,
    M4,MC, M4,PC, MC,PC, M4,MC, MC,PC, MC,MC,
    MC,M4, MC,MC, PC,MC, MC,M4, PC,MC, PC,M4};

  // multipliers in thousandths, in issue order
  function automatic logic [11:0] milli_of(logic [2:0] idx);
    logic [11:0] m;
    case (idx)
      3'd0:    m = 12'd4000;
      3'd1:    m = 12'd2000;
      3'd2:    m = 12'd2828;
      3'd3:    m = 12'd2660;
      3'd4:    m = 12'd1330;
      3'd5:    m = 12'd660;
      default: m = 12'd1000;
    endcase
    return m;
  endfunction

  // base shape of each thicker variant
  function automatic logic [5:0] variant_base(logic [4:0] r);
    logic [5:0] b;
    case (r)
      5'd0:    b = 6'd2;
      5'd1:    b = 6'd3;
      5'd2:    b = 6'd5;
      5'd3:    b = 6'd24;
      5'd4:    b = 6'd25;
      5'd5:    b = 6'd26;
      5'd6:    b = 6'd27;
      5'd7:    b = 6'd28;
      5'd8:    b = 6'd30;
      5'd9:    b = 6'd32;
      5'd10:   b = 6'd35;
      5'd11:   b = 6'd36;
      5'd12:   b = 6'd37;
      5'd13:   b = 6'd38;
      5'd14:   b = 6'd40;
      5'd15:   b = 6'd42;
      5'd16:   b = 6'd44;
      5'd17:   b = 6'd46;
      default: b = 6'd0;
    endcase
    return b;
  endfunction

  function automatic logic [4:0] pat_len(pat_t p);
    logic [4:0] n;
    unique case (p)
      PAT_PLUS, PAT_MULT, PAT_DSML, PAT_TUP, PAT_TDN:   n = 5'd4;
      PAT_DMED, PAT_SQR, PAT_DIAM:                      n = 5'd5;
      PAT_STAR, PAT_DCRS, PAT_SQDG:                     n = 5'd8;
      PAT_F3TR, PAT_DDIA:                               n = 5'd9;
      PAT_TRI3:                                         n = 5'd10;
      PAT_OSTAR, PAT_O4TP:                              n = 5'd11;
      PAT_F4TX, PAT_F4TP:                               n = 5'd12;
      PAT_CROSS, PAT_O4TX, PAT_CRSX:                    n = 5'd13;
      PAT_OCTX:                                         n = 5'd15;
      PAT_CRST, PAT_CXTR:                               n = 5'd18;
      PAT_STRT, PAT_DDTR, PAT_FSQX, PAT_FSQP:           n = 5'd24;
      default:                                          n = 5'd0;
    endcase
    return n;
  endfunction

  // base shape number to kind and pattern
  function automatic cls_t classify(logic [9:0] base, logic pt);
    cls_t c;
    c.kind = KIND_DOT;
    c.pat  = PAT_NONE;
    unique case (base) inside
      10'd2:         begin c.kind = KIND_SEG;   c.pat = PAT_PLUS;  end
      10'd3, 10'd31: begin c.kind = KIND_SEG;   c.pat = PAT_STAR;  end
      10'd4, 10'd24: begin c.kind = KIND_CIRC;  end
      10'd5:         begin c.kind = KIND_SEG;   c.pat = PAT_MULT;  end
      10'd6:         begin c.kind = KIND_SEG;   c.pat = PAT_DSML;  end
      10'd7:         begin c.kind = KIND_FAREA; c.pat = PAT_DMED;  end
      10'd8, 10'd20: begin c.kind = KIND_FCIRC; end
      10'd21:        begin c.kind = KIND_FAREA; c.pat = PAT_SQR;   end
      10'd25:        begin c.kind = KIND_PLINE; c.pat = PAT_SQR;   end
      10'd22:        begin c.kind = KIND_FAREA; c.pat = PAT_TUP;   end
      10'd26:        begin c.kind = KIND_PLINE; c.pat = PAT_TUP;   end
      10'd23:        begin c.kind = KIND_FAREA; c.pat = PAT_TDN;   end
      10'd32:        begin c.kind = KIND_PLINE; c.pat = PAT_TDN;   end
      10'd27:        begin c.kind = KIND_PLINE; c.pat = PAT_DIAM;  end
      10'd33:        begin c.kind = KIND_FAREA; c.pat = PAT_DIAM;  end
      10'd34: begin
        c.kind = pt ? KIND_TRI : KIND_FAREA;
        c.pat  = pt ? PAT_CRST : PAT_CROSS;
      end
      10'd28:        begin c.kind = KIND_PLINE; c.pat = PAT_CROSS; end
      10'd29: begin
        c.kind = pt ? KIND_TRI : KIND_FAREA;
        c.pat  = pt ? PAT_STRT : PAT_OSTAR;
      end
      10'd30:        begin c.kind = KIND_PLINE; c.pat = PAT_OSTAR; end
      10'd35:        begin c.kind = KIND_PLINE; c.pat = PAT_DCRS;  end
      10'd36:        begin c.kind = KIND_PLINE; c.pat = PAT_SQDG;  end
      10'd37:        begin c.kind = KIND_PLINE; c.pat = PAT_TRI3;  end
      10'd38:        begin c.kind = KIND_PLINE; c.pat = PAT_OCTX;  end
      10'd39:        begin c.kind = KIND_TRI;   c.pat = PAT_F3TR;  end
      10'd40:        begin c.kind = KIND_PLINE; c.pat = PAT_O4TX;  end
      10'd41:        begin c.kind = KIND_TRI;   c.pat = PAT_F4TX;  end
      10'd43: begin
        c.kind = pt ? KIND_TRI : KIND_FAREA;
        c.pat  = pt ? PAT_DDTR : PAT_DDIA;
      end
      10'd42:        begin c.kind = KIND_PLINE; c.pat = PAT_DDIA;  end
      10'd44:        begin c.kind = KIND_PLINE; c.pat = PAT_O4TP;  end
      10'd45:        begin c.kind = KIND_TRI;   c.pat = PAT_F4TP;  end
      10'd47: begin
        c.kind = pt ? KIND_TRI : KIND_FAREA;
        c.pat  = pt ? PAT_CXTR : PAT_CRSX;
      end
      10'd46:        begin c.kind = KIND_PLINE; c.pat = PAT_CRSX;  end
      10'd48:        begin c.kind = KIND_TRI;   c.pat = PAT_FSQX;  end
      10'd49:        begin c.kind = KIND_TRI;   c.pat = PAT_FSQP;  end
      default: ;
    endcase
    c.len = pat_len(c.pat);
    return c;
  endfunction

  // x and y codes of vertex k of a pattern
  function automatic logic [VW-1:0] pat_vertex(pat_t p, logic [4:0] k);
    logic [PAT_W-1:0] tbl;
    int               top;
    unique case (p)
      PAT_PLUS:  tbl = PV_PLUS;
      PAT_STAR:  tbl = PV_STAR;
      PAT_MULT:  tbl = PV_MULT;
      PAT_DSML:  tbl = PV_DSML;
      PAT_DMED:  tbl = PV_DMED;
      PAT_SQR:   tbl = PV_SQR;
      PAT_TUP:   tbl = PV_TUP;
      PAT_TDN:   tbl = PV_TDN;
      PAT_DIAM:  tbl = PV_DIAM;
      PAT_CRST:  tbl = PV_CRST;
      PAT_CROSS: tbl = PV_CROSS;
      PAT_STRT:  tbl = PV_STRT;
      PAT_OSTAR: tbl = PV_OSTAR;
      PAT_DCRS:  tbl = PV_DCRS;
      PAT_SQDG:  tbl = PV_SQDG;
      PAT_TRI3:  tbl = PV_TRI3;
      PAT_OCTX:  tbl = PV_OCTX;
      PAT_F3TR:  tbl = PV_F3TR;
      PAT_O4TX:  tbl = PV_O4TX;
      PAT_F4TX:  tbl = PV_F4TX;
      PAT_DDTR:  tbl = PV_DDTR;
      PAT_DDIA:  tbl = PV_DDIA;
      PAT_O4TP:  tbl = PV_O4TP;
      PAT_F4TP:  tbl = PV_F4TP;
      PAT_CXTR:  tbl = PV_CXTR;
      PAT_CRSX:  tbl = PV_CRSX;
      PAT_FSQX:  tbl = PV_FSQX;
      PAT_FSQP:  tbl = PV_FSQP;
      default:   tbl = '0;
    endcase
    top = (k < 5'(NV)) ? (PAT_W - 1 - VW * int'(k)) : (VW - 1);
    return tbl[top -: VW];
  endfunction

endpackage

/* design/pmv_front.sv */
// ----------------------------------------------------------------------------
// pmv_front
// Accepts requests, classifies the style and computes the rounded multiples.
// ----------------------------------------------------------------------------
module pmv_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_scale,
  input  logic               in_prefer_triangles,
  input  logic [9:0]         style_i,
  input  logic [15:0]        size_i,
  output pmv_pkg::job_t      job_o,
  output logic               job_valid_o,
  input  logic               job_ready_i
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_RUN  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  localparam logic [28:0] RND_HALF = 29'd32768000;
  localparam logic [30:0] RECIP    = 31'd1099511627;  // floor(2^40 / 1000)
  localparam logic [9:0]  THOUSAND = 10'd1000;

  fstate_t state_r, state_nxt;
  logic [2:0] iss_r, iss_nxt;

  logic [15:0]        scale_r;
  logic signed [16:0] diff_r;
  pmv_pkg::cls_t      cls_r;
  logic [31:0]        absr_r;
  logic               neg_r;

  logic        v1_r, v2_r, v3_r, v4_r;
  logic [2:0]  idx1_r, idx2_r, idx3_r, idx4_r;
  logic [43:0] m1_r;
  logic [28:0] y2_r, y3_r, y4_r;
  logic [59:0] t3_r;
  logic [19:0] q4_r;
  logic [29:0] p4_r;
  logic [pmv_pkg::NUM_MAG-1:0][pmv_pkg::MAG_W-1:0] mag_r;

  // style decode
  logic [9:0]         d_style;
  logic [21:0]        q_prod;
  logic [5:0]         q_blk;
  logic [9:0]         r_full;
  logic               is_var;
  logic [9:0]         base;
  logic [5:0]         half_sum;
  logic [4:0]         half;
  logic signed [16:0] diff;
  logic               accept;

  assign d_style  = style_i - pmv_pkg::VARIANT_FIRST;
  assign q_prod   = d_style * 12'd3641;            // divide by 18
  assign q_blk    = q_prod[21:16];
  assign r_full   = d_style - 10'(q_blk * 5'd18);
  assign is_var   = (style_i >= pmv_pkg::VARIANT_FIRST);
  assign base     = is_var ? {4'd0, pmv_pkg::variant_base(r_full[4:0])} : style_i;
  assign half_sum = q_blk + 6'd2;
  assign half     = is_var ? half_sum[5:1] : 5'd0;
  assign diff     = $signed({1'b0, size_i}) - $signed({1'b0, half, 6'd0, 5'd0} >> 5);

  assign in_ready = (state_r == F_IDLE);
  assign accept   = in_valid && in_ready;

  // multiply by scale and split sign
  logic signed [33:0] r_prod;
  logic [33:0]        r_abs;
  assign r_prod = $signed({1'b0, scale_r}) * diff_r;
  assign r_abs  = r_prod[33] ? 34'(-r_prod) : r_prod;

  // final correction of the reciprocal quotient
  logic [29:0] rem4;
  logic [19:0] q_fin;
  logic [19:0] mag_val;
  assign rem4    = {1'b0, y4_r} - p4_r;
  assign q_fin   = q4_r + {19'd0, (rem4 >= {20'd0, THOUSAND})};
  assign mag_val = neg_r ? 20'(-q_fin) : q_fin;

  always_comb begin
    state_nxt = state_r;
    iss_nxt   = iss_r;
    unique case (state_r)
      F_IDLE: if (accept) state_nxt = F_MUL;
      F_MUL: begin
        state_nxt = F_RUN;
        iss_nxt   = 3'd0;
      end
      F_RUN: begin
        if (iss_r != 3'd7) iss_nxt = iss_r + 3'd1;
        if (v4_r && idx4_r == pmv_pkg::MAG_LAST) state_nxt = F_PUSH;
      end
      F_PUSH: if (job_ready_i) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      iss_r   <= 3'd7;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iss_r   <= iss_nxt;
      v1_r    <= (state_r == F_RUN) && (iss_r != 3'd7);
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scale_r <= in_scale;
      diff_r  <= diff;
      cls_r   <= pmv_pkg::classify(base, in_prefer_triangles);
    end
    if (state_r == F_MUL) begin
      neg_r  <= r_prod[33];
      absr_r <= r_abs[31:0];
    end
    idx1_r <= iss_r;
    m1_r   <= absr_r * pmv_pkg::milli_of(iss_r);
    idx2_r <= idx1_r;
    y2_r   <= 29'((m1_r + {15'd0, RND_HALF}) >> 16);
    idx3_r <= idx2_r;
    y3_r   <= y2_r;
    t3_r   <= y2_r * RECIP;
    idx4_r <= idx3_r;
    y4_r   <= y3_r;
    q4_r   <= t3_r[59:40];
    p4_r   <= t3_r[59:40] * THOUSAND;
    if (v4_r) mag_r[idx4_r] <= mag_val;
  end

  assign job_o.cls   = cls_r;
  assign job_o.mag   = mag_r;
  assign job_valid_o = (state_r == F_PUSH);

endmodule

/* design/pmv_queue.sv */
// ----------------------------------------------------------------------------
// pmv_queue
// Short first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
module pmv_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pmv_pkg::job_t push_data_i,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  output pmv_pkg::job_t pop_data_o,
  output logic          pop_valid_o,
  input  logic          pop_i
);

  localparam int AW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  pmv_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0]   wr_r, rd_r;
  logic [CNTW-1:0] cnt_r;
  logic            push, pop;

  assign push_ready_o = (cnt_r != CNTW'(DEPTH));
  assign pop_valid_o  = (cnt_r != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
      if (pop)  rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CNTW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data_i;
  end

endmodule

/* design/pmv_back.sv */
// ----------------------------------------------------------------------------
// pmv_back
// Walks the vertex pattern of the queued request, one result per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module pmv_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pmv_pkg::job_t      job_i,
  input  logic               job_valid_i,
  output logic               pop_o,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_shape_kind,
  output logic signed [20:0] out_circle_diameter,
  output logic               out_has_vertex,
  output logic signed [19:0] out_vertex_x,
  output logic signed [19:0] out_vertex_y,
  output logic               out_last
);

  logic [4:0] k_r;
  logic       valid_r;
  logic [2:0]  kind_r;
  logic [20:0] diam_r;
  logic        hasv_r, last_r;
  logic [19:0] x_r, y_r;

  logic        advance, no_vtx, is_last, is_circ;
  logic [9:0]  codes;

  function automatic logic [19:0] coord(logic [4:0] c,
                                        logic [pmv_pkg::NUM_MAG-1:0][19:0] mag);
    logic [4:0]  mg;
    logic [19:0] v;
    mg = c[4] ? 5'(-c) : c;
    if (mg == 5'd0)      v = 20'd0;
    else if (mg == 5'd1) v = 20'd1;
    else                 v = mag[3'(mg - 5'd2)];
    return c[4] ? 20'(-v) : v;
  endfunction

  assign advance = job_valid_i && (!valid_r || out_ready);
  assign no_vtx  = (job_i.cls.len == 5'd0);
  assign is_last = no_vtx || (k_r == job_i.cls.len - 5'd1);
  assign is_circ = (job_i.cls.kind == pmv_pkg::KIND_CIRC) ||
                   (job_i.cls.kind == pmv_pkg::KIND_FCIRC);
  assign codes   = pmv_pkg::pat_vertex(job_i.cls.pat, k_r);
  assign pop_o   = advance && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      k_r     <= 5'd0;
    end else begin
      if (advance)        valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
      if (advance) k_r <= is_last ? 5'd0 : k_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r <= job_i.cls.kind;
      last_r <= is_last;
      hasv_r <= !no_vtx;
      diam_r <= (no_vtx && is_circ) ? {job_i.mag[0], 1'b0} : 21'd0;
      x_r    <= no_vtx ? 20'd0 : coord(codes[9:5], job_i.mag);
      y_r    <= no_vtx ? 20'd0 : coord(codes[4:0], job_i.mag);
    end
  end

  assign out_valid           = valid_r;
  assign out_shape_kind      = kind_r;
  assign out_circle_diameter = diam_r;
  assign out_has_vertex      = hasv_r;
  assign out_vertex_x        = x_r;
  assign out_vertex_y        = y_r;
  assign out_last            = last_r;

endmodule

/* design/plot_marker_vertex_generator.sv */
// ----------------------------------------------------------------------------
// plot_marker_vertex_generator
// Marker request to shape kind, circle diameter and vertex list.
// ----------------------------------------------------------------------------
// front: one multiply, seven multiples through a reciprocal rounding pipeline,
//   then a push into the queue; no new request is taken until that push
// back: one result per cycle unless the output stalls, max(vertex count, 1) results
//   per request, with up to 24 vertices; the queue lets the front work ahead
// reset: synchronous active low; style 1, size 1.0, queue empty, no output
module plot_marker_vertex_generator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_scale,
  input  logic               in_prefer_triangles,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_shape_kind,
  output logic signed [20:0] out_circle_diameter,
  output logic               out_has_vertex,
  output logic signed [19:0] out_vertex_x,
  output logic signed [19:0] out_vertex_y,
  output logic               out_last,
  // configuration writes
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata
);

  // configuration registers
  logic [9:0]  style_r;
  logic [15:0] size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      style_r <= pmv_pkg::STYLE_RESET;
      size_r  <= pmv_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pmv_pkg::REG_STYLE: style_r <= cfg_wdata[9:0];
        pmv_pkg::REG_SIZE:  size_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front to queue
  pmv_pkg::job_t f_job;
  logic          f_valid, f_ready;
  // queue to back
  pmv_pkg::job_t q_job;
  logic          q_valid, q_pop;

  // classify the request and build the rounded multiples
  pmv_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_scale            (in_scale),
    .in_prefer_triangles (in_prefer_triangles),
    .style_i             (style_r),
    .size_i              (size_r),
    .job_o               (f_job),
    .job_valid_o         (f_valid),
    .job_ready_i         (f_ready)
  );

  // decouples the front from result back-pressure
  pmv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_data_i  (f_job),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_data_o   (q_job),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop)
  );

  // emit one result per transfer from the registered output stage
  pmv_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_i               (q_job),
    .job_valid_i         (q_valid),
    .pop_o               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_shape_kind      (out_shape_kind),
    .out_circle_diameter (out_circle_diameter),
    .out_has_vertex      (out_has_vertex),
    .out_vertex_x        (out_vertex_x),
    .out_vertex_y        (out_vertex_y),
    .out_last            (out_last)
  );

endmodule

/* design/pmv_checker.sv */
// ----------------------------------------------------------------------------
// pmv_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pmv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_shape_kind,
  input logic signed [20:0] out_circle_diameter,
  input logic               out_has_vertex,
  input logic signed [19:0] out_vertex_x,
  input logic signed [19:0] out_vertex_y,
  input logic               out_last
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex_x) &&
    $stable(out_vertex_y) && $stable(out_last))
    else $error("stalled result changed");

  // a vertex-less result closes its request
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_vertex |-> out_last &&
    out_vertex_x == 20'sd0 && out_vertex_y == 20'sd0)
    else $error("vertex-less result not final");

  // vertices never come with a diameter nor with dot or circle kinds
  a_vertex_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_vertex |-> out_circle_diameter == 21'sd0 &&
    out_shape_kind != pmv_pkg::KIND_DOT && out_shape_kind != pmv_pkg::KIND_CIRC &&
    out_shape_kind != pmv_pkg::KIND_FCIRC)
    else $error("vertex with wrong kind or diameter");

  // only circles carry a diameter
  a_diam_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_shape_kind != pmv_pkg::KIND_CIRC &&
    out_shape_kind != pmv_pkg::KIND_FCIRC |-> out_circle_diameter == 21'sd0)
    else $error("diameter on a non-circle");

endmodule

bind plot_marker_vertex_generator pmv_checker u_pmv_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the plot marker vertex generator: a behavioral
// marker generator predicts every result of each transfer, results are
// compared field by field in order, and style and size are swept through
// directed corners and random requests under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

  // magnitude selectors of the pattern coordinates
  localparam int KU = 1;  // one pixel
  localparam int K4 = 2;  // 4 x reduced
  localparam int K2 = 3;  // 2 x reduced
  localparam int KS = 4;  // 2.828 x reduced
  localparam int KD = 5;  // 2.66 x reduced
  localparam int KC = 6;  // 1.33 x reduced
  localparam int KE = 7;  // 0.66 x reduced
  localparam int K1 = 8;  // 1 x reduced

  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 10;

  // base shape repeated by each thicker variant
  localparam int VAR_BASE [18] = '{2, 3, 5, 24, 25, 26, 27, 28, 30, 32, 35, 36, 37, 38,
                                   40, 42, 44, 46};

  typedef struct {
    pmv_pkg::kind_t     kind;
    logic signed [20:0] diam;
    logic               hv;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic               last;
  } marker_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [15:0]        in_scale;
  logic               in_prefer_triangles;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_shape_kind;
  logic signed [20:0] out_circle_diameter;
  logic               out_has_vertex;
  logic signed [19:0] out_vertex_x;
  logic signed [19:0] out_vertex_y;
  logic               out_last;
  logic               cfg_we;
  logic               cfg_index;
  logic [15:0]        cfg_wdata;

  // shadow copy of the configuration registers
  logic [9:0]  style_shadow;
  logic [15:0] size_shadow;

  marker_result_t expected_results [$];
  int             send_idle_pct;
  int             recv_idle_pct;
  int             mismatch_count;

  plot_marker_vertex_generator DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_scale            (in_scale),
    .in_prefer_triangles (in_prefer_triangles),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_shape_kind      (out_shape_kind),
    .out_circle_diameter (out_circle_diameter),
    .out_has_vertex      (out_has_vertex),
    .out_vertex_x        (out_vertex_x),
    .out_vertex_y        (out_vertex_y),
    .out_last            (out_last),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // round(r * milli / 1000), r in Q16.16, halves away from zero
  function automatic longint round_multiple(longint r, longint milli);
    longint m;
    longint q;
    m = (r < 0 ? -r : r) * milli;
    q = (m + 64'd32768000) / 64'd65536000;
    return r < 0 ? -q : q;
  endfunction

  // expected results of one request under the current configuration
  task automatic predict_marker(input logic [15:0] scale, input logic pt);
    int             base;
    int             half;
    longint         reduced;
    longint         mag [9];
    longint         diam;
    pmv_pkg::kind_t kind;
    int             pts [$];
    int             n;
    int             cx;
    int             cy;
    marker_result_t res;
    base = style_shadow;
    half = 0;
    diam = 0;
    kind = pmv_pkg::KIND_DOT;
    pts  = {};
    if (style_shadow >= 50) begin
      base = VAR_BASE[(style_shadow - 50) % 18];
      half = ((style_shadow - 50) / 18 + 2) / 2;
    end
    reduced = longint'(scale) * (longint'(size_shadow) - longint'(half) * 64);
    mag[0]  = 0;
    mag[KU] = 1;
    mag[K4] = round_multiple(reduced, 4000);
    mag[K2] = round_multiple(reduced, 2000);
    mag[KS] = round_multiple(reduced, 2828);
    mag[KD] = round_multiple(reduced, 2660);
    mag[KC] = round_multiple(reduced, 1330);
    mag[KE] = round_multiple(reduced, 660);
    mag[K1] = round_multiple(reduced, 1000);

    case (base)
      2: begin
        kind = pmv_pkg::KIND_SEG; pts = {-K4,0, K4,0, 0,-K4, 0,K4};
      end
      3, 31: begin
        kind = pmv_pkg::KIND_SEG;
        pts = {-K4,0, K4,0, 0,-K4, 0,K4, -KS,-KS, KS,KS, -KS,KS, KS,-KS};
      end
      4, 24: begin
        kind = pmv_pkg::KIND_CIRC; diam = 2 * mag[K4];
      end
      5: begin
        kind = pmv_pkg::KIND_SEG; pts = {-KS,-KS, KS,KS, -KS,KS, KS,-KS};
      end
      // small dot: fixed one-pixel vertices
      6: begin
        kind = pmv_pkg::KIND_SEG; pts = {-KU,0, KU,0, 0,-KU, 0,KU};
      end
      7: begin
        kind = pmv_pkg::KIND_FAREA; pts = {-KU,-KU, KU,-KU, KU,KU, -KU,KU, -KU,-KU};
      end
      8, 20: begin
        kind = pmv_pkg::KIND_FCIRC; diam = 2 * mag[K4];
      end
      21, 25: begin
        kind = (base == 21) ? pmv_pkg::KIND_FAREA : pmv_pkg::KIND_PLINE;
        pts = {-K4,-K4, K4,-K4, K4,K4, -K4,K4, -K4,-K4};
      end
      22, 26: begin
        kind = (base == 22) ? pmv_pkg::KIND_FAREA : pmv_pkg::KIND_PLINE;
        pts = {-K4,K4, K4,K4, 0,-K4, -K4,K4};
      end
      23, 32: begin
        kind = (base == 23) ? pmv_pkg::KIND_FAREA : pmv_pkg::KIND_PLINE;
        pts = {0,K4, K4,-K4, -K4,-K4, 0,K4};
      end
      27, 33: begin
        kind = (base == 33) ? pmv_pkg::KIND_FAREA : pmv_pkg::KIND_PLINE;
        pts = {-KD,0, 0,-K4, KD,0, 0,K4, -KD,0};
      end
      28, 34: begin
        if (base == 34 && pt) begin
          kind = pmv_pkg::KIND_TRI;
          pts = {-K4,-KC, -K4,KC, -KC,KC, -K4,-KC, -KC,KC, -KC,-KC,
                 -KC,-K4, -KC,K4, KC,K4, -KC,-K4, KC,K4, KC,-K4,
                 KC,-KC, KC,KC, K4,KC, KC,-KC, K4,KC, K4,-KC};
        end else begin
          kind = (base == 34) ? pmv_pkg::KIND_FAREA : pmv_pkg::KIND_PLINE;
          pts = {-K4,-KC, -KC,-KC, -KC,-K4, KC,-K4, KC,-KC, K4,-KC,
                 K4,KC, KC,KC, KC,K4, -KC,K4, -KC,KC, -K4,KC, -K4,-KC};
        end
      end
      29, 30: begin
        if (base == 29 && pt) begin
          kind = pmv_pkg::KIND_TRI;
          pts = {-K4,KC, -K2,-KE, -KC,KC, -K2,-KE, -KD,-K4, 0,-K2,
                 0,-K2, KD,-K4, K2,-KE, K2,-KE, K4,KC, KC,KC,
                 KC,KC, 0,K4, -KC,KC, -KC,KC, -K2,-KE, 0,-K2,
                 -KC,KC, 0,-K2, K2,-KE, -KC,KC, K2,-KE, KC,KC};
        end else begin
          kind = (base == 29) ? pmv_pkg::KIND_FAREA : pmv_pkg::KIND_PLINE;
          pts = {-K4,KC, -K2,-KE, -KD,-K4, 0,-K2, KD,-K4, K2,-KE,
                 K4,KC, KC,KC, 0,K4, -KC,KC, -K4,KC};
        end
      end
      35: begin
        kind = pmv_pkg::KIND_PLINE;
        pts = {-K4,0, 0,-K4, K4,0, 0,K4, -K4,0, K4,0, 0,K4, 0,-K4};
      end
      36: begin
        kind = pmv_pkg::KIND_PLINE;
        pts = {-K4,-K4, K4,-K4, K4,K4, -K4,K4, -K4,-K4, K4,K4, -K4,K4, K4,-K4};
      end
      37: begin
        kind = pmv_pkg::KIND_PLINE;
        pts = {0,0, -K2,K4, K2,K4, 0,0, -K2,-K4, -K4,0, 0,0, K4,0, K2,-K4, 0,0};
      end
      38: begin
        kind = pmv_pkg::KIND_PLINE;
        pts = {-K4,0, -K4,-K2, -K2,-K4, K2,-K4, K4,-K2, K4,K2, K2,K4,
               -K2,K4, -K4,K2, -K4,0, K4,0, 0,0, 0,-K4, 0,K4, 0,0};
      end
      39: begin
        kind = pmv_pkg::KIND_TRI;
        pts = {-K4,0, -K2,K4, 0,0, K2,K4, K4,0, 0,0, K2,-K4, -K2,-K4, 0,0};
      end
      40: begin
        kind = pmv_pkg::KIND_PLINE;
        pts = {0,0, K2,K4, K4,K2, 0,0, K4,-K2, K2,-K4, 0,0,
               -K2,-K4, -K4,-K2, 0,0, -K4,K2, -K2,K4, 0,0};
      end
      41: begin
        kind = pmv_pkg::KIND_TRI;
        pts = {-K4,K2, -K2,K4, 0,0, K2,K4, K4,K2, 0,0,
               K4,-K2, K2,-K4, 0,0, -K2,-K4, -K4,-K2, 0,0};
      end
      42, 43: begin
        if (base == 43 && pt) begin
          kind = pmv_pkg::KIND_TRI;
          pts = {0,K4, -K1,K1, 0,0, -K1,K1, -K4,0, 0,0,
                 -K4,0, -K1,-K1, 0,0, -K1,-K1, 0,-K4, 0,0,
                 0,-K4, K1,-K1, 0,0, K1,-K1, K4,0, 0,0,
                 K4,0, K1,K1, 0,0, K1,K1, 0,K4, 0,0};
        end else begin
          kind = (base == 43) ? pmv_pkg::KIND_FAREA : pmv_pkg::KIND_PLINE;
          pts = {0,K4, -K1,K1, -K4,0, -K1,-K1, 0,-K4, K1,-K1, K4,0, K1,K1, 0,K4};
        end
      end
      44: begin
        kind = pmv_pkg::KIND_PLINE;
        pts = {0,0, K2,K4, -K2,K4, K2,-K4, -K2,-K4, 0,0,
               K4,K2, K4,-K2, -K4,K2, -K4,-K2, 0,0};
      end
      45: begin
        kind = pmv_pkg::KIND_TRI;
        pts = {-K2,K4, K2,K4, 0,0, K4,K2, K4,-K2, 0,0,
               K2,-K4, -K2,-K4, 0,0, -K4,-K2, -K4,K2, 0,0};
      end
      46, 47: begin
        if (base == 47 && pt) begin
          kind = pmv_pkg::KIND_TRI;
          pts = {-K2,0, -K4,K2, -K2,K4, -K2,0, -K2,K4, 0,K2,
                 -K2,-K4, -K4,-K2, K2,K4, -K2,-K4, K2,K4, K4,K2,
                 K2,-K4, 0,-K2, K2,0, K2,-K4, K2,0, K4,-K2};
        end else begin
          kind = (base == 47) ? pmv_pkg::KIND_FAREA : pmv_pkg::KIND_PLINE;
          pts = {0,K2, -K2,K4, -K4,K2, -K2,0, -K4,-K2, -K2,-K4, 0,-K2,
                 K2,-K4, K4,-K2, K2,0, K4,K2, K2,K4, 0,K2};
        end
      end
      48: begin
        kind = pmv_pkg::KIND_TRI;
        pts = {-K2,0, -K4,K2, -K2,K4, -K2,0, -K2,K4, 0,K2,
               K2,0, 0,K2, K2,K4, K2,0, K2,K4, K4,K2,
               -K2,-K4, -K4,-K2, -K2,0, -K2,-K4, -K2,0, 0,-K2,
               K2,-K4, 0,-K2, K2,0, K2,-K4, K2,0, K4,-K2};
      end
      49: begin
        kind = pmv_pkg::KIND_TRI;
        pts = {-KC,KC, -KC,K4, KC,K4, -KC,KC, KC,K4, KC,KC,
               KC,-KC, KC,KC, K4,KC, KC,-KC, K4,KC, K4,-KC,
               -K4,-KC, -K4,KC, -KC,KC, -K4,-KC, -KC,KC, -KC,-KC,
               -KC,-K4, -KC,-KC, KC,-KC, -KC,-K4, KC,-KC, KC,-K4};
      end
      // style 0, 1, 9 to 19 and the unlisted rest: dot
      default: kind = pmv_pkg::KIND_DOT;
    endcase

    n = pts.size() / 2;
    if (n == 0) begin
      res.kind = kind;
      res.diam = diam[20:0];
      res.hv   = 1'b0;
      res.x    = '0;
      res.y    = '0;
      res.last = 1'b1;
      expected_results.push_back(res);
    end else begin
      for (int k = 0; k < n; k++) begin
        cx = pts[2*k];
        cy = pts[2*k+1];
        res.kind = kind;
        res.diam = '0;
        res.hv   = 1'b1;
        res.x    = (cx < 0) ? 20'(-mag[-cx]) : 20'(mag[cx]);
        res.y    = (cy < 0) ? 20'(-mag[-cy]) : 20'(mag[cy]);
        res.last = (k == n - 1);
        expected_results.push_back(res);
      end
    end
  endtask

  // drop valid and wait until all outstanding results have come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == pmv_pkg::REG_STYLE) style_shadow = value[9:0];
    else                           size_shadow  = value;
    @(posedge clk);
  endtask

  // one request transfer, with an optional random gap in front
  task automatic send_request(input logic [15:0] scale, input logic pt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 60);
    end
    in_valid            <= 1'b1;
    in_scale            <= scale;
    in_prefer_triangles <= pt;
    do @(posedge clk); while (!in_ready);
    predict_marker(scale, pt);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    marker_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: kind %0d x %0d y %0d", out_shape_kind,
                   out_vertex_x, out_vertex_y);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_shape_kind !== exp_res.kind || out_circle_diameter !== exp_res.diam ||
            out_has_vertex !== exp_res.hv || out_vertex_x !== exp_res.x ||
            out_vertex_y !== exp_res.y || out_last !== exp_res.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"mismatch: exp kind %0d diam %0d hv %0d x %0d y %0d last %0d",
                      " / got kind %0d diam %0d hv %0d x %0d y %0d last %0d"},
                     exp_res.kind, exp_res.diam, exp_res.hv, exp_res.x, exp_res.y,
                     exp_res.last, out_shape_kind, out_circle_diameter, out_has_vertex,
                     out_vertex_x, out_vertex_y, out_last);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // reset values, scale corners and the triangle flag
  task automatic test_reset_defaults();
    send_request(16'h0000, 1'b0);
    send_request(16'hFFFF, 1'b1);
    send_request(16'h0100, 1'b0);
  endtask

  // every base style and the variant styles 50 to 85, both triangle settings for 29, 34, 43, 47
  task automatic test_style_sweep();
    write_reg(pmv_pkg::REG_SIZE, 16'h0100);
    for (int s = 0; s < 50 + 18 * 2; s++) begin
      write_reg(pmv_pkg::REG_STYLE, 16'(s));
      send_request(16'($urandom_range(16'hFFFF)), 1'b0);
      if (s inside {29, 34, 43, 47}) send_request(16'hFFFF, 1'b1);
    end
  endtask

  // size and scale corners, including a negative reduced size
  task automatic test_size_extremes();
    write_reg(pmv_pkg::REG_STYLE, 16'd1023);
    write_reg(pmv_pkg::REG_SIZE, 16'h0000);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h5555, 1'b1);
    write_reg(pmv_pkg::REG_STYLE, 16'd49);
    write_reg(pmv_pkg::REG_SIZE, 16'hFFFF);
    send_request(16'hFFFF, 1'b1);
    send_request(16'h0001, 1'b0);
    write_reg(pmv_pkg::REG_STYLE, 16'd8);
    send_request(16'hFFFF, 1'b0);
    write_reg(pmv_pkg::REG_STYLE, 16'd1000);
    write_reg(pmv_pkg::REG_SIZE, 16'd1700);
    send_request(16'hAAAA, 1'b0);
  endtask

  // random configuration phases of random requests
  task automatic test_random_requests(input int n_items);
    logic [15:0] scale;
    int          pick;
    for (int i = 0; i < n_items; i++) begin
      if (i % 12 == 0) begin
        // the config write also holds the sender until all results are back
        pick = $urandom_range(9);
        write_reg(pmv_pkg::REG_STYLE, (pick < 6) ? 16'($urandom_range(49)) :
                  (pick < 9) ? 16'($urandom_range(1023, 50)) : 16'd1023);
        pick = $urandom_range(9);
        write_reg(pmv_pkg::REG_SIZE, (pick < 4) ? 16'($urandom_range(16'hFFFF)) :
                  (pick < 8) ? 16'($urandom_range(2000)) :
                  (pick < 9) ? 16'h0000 : 16'hFFFF);
      end
      pick  = $urandom_range(9);
      scale = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'h0000 : 16'($urandom_range(16'hFFFF));
      send_request(scale, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_scale            = '0;
    in_prefer_triangles = 1'b0;
    out_ready           = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = pmv_pkg::REG_STYLE;
    cfg_wdata           = '0;
    style_shadow        = pmv_pkg::STYLE_RESET;
    size_shadow         = pmv_pkg::SIZE_RESET;
    mismatch_count      = 0;
    send_idle_pct       = 26;
    recv_idle_pct       = 81;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_style_sweep();
    test_size_extremes();
    test_random_requests(50);
    send_idle_pct = 81;
    recv_idle_pct = 26;
    test_random_requests(50);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_requests(50);
    drain_results();

    if (mismatch_count == 0) $display("[plot_marker_vertex_generator] OK");
    else $display("[plot_marker_vertex_generator] ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("[plot_marker_vertex_generator] ERROR");
    $finish;
  end

endmodule
